>>> hdl/cascade_fir_filter_unit_assert.svh
// assertion macros for the cascade fir filter unit
// expects clk and rst in the scope where a macro is used
`ifndef CASCADE_FIR_FILTER_UNIT_ASSERT_SVH
`define CASCADE_FIR_FILTER_UNIT_ASSERT_SVH

// same-cycle implication
`define CFFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CFFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/cffu_pkg.sv
// shared types and constants for the cascade fir filter unit
// used by cffu_ctrl, cffu_datapath and cascade_fir_filter_unit
package cffu_pkg;

  localparam int DEF_STAGES          = 16;
  localparam int DEF_SCALE_SHIFT     = 5;
  localparam int DEF_COEFF_FRAC_BITS = 14;
  localparam int DEF_SAMPLE_WIDTH    = 16;

  localparam int MAX_STAGES   = 16;
  localparam int SECT_FIELD_W = 4;
  localparam int STEP_W       = 6;
  localparam int NUM_REGS     = 8;
  localparam int REG_SEL_W    = 3;
  localparam int CFG_INDEX_W  = 4;
  localparam int REG_W        = 64;
  localparam int COEFF_W      = 16;
  localparam int ACC_W        = 32;
  localparam int PROD_W       = ACC_W + COEFF_W;
  localparam int SUM_W        = PROD_W + 2;

  localparam logic signed [SUM_W-1:0] ACC_MAX =
    {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                    load;
    logic                    issue;
    logic                    tap;
    logic [SECT_FIELD_W-1:0] sect;
    logic                    use_prod;
    logic                    use_tap;
    logic                    finish;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

>>> hdl/cascade_fir_filter_unit.sv
// channel   | signals                                  | word
// in        | in_valid, in_ready, sample_in            | one input sample
// out       | out_valid, out_ready, sample_out, clipped| one filtered sample
// cfg       | cfg_valid, cfg_ready, cfg_index, cfg_data| one coefficient register
//
// a new sample is taken only after the last one has run through every section,
// set by the single shared multiplier, one coefficient tap per cycle
// the result sits in an output register; the next sample is taken while it waits
// a finished sample stalls in its last cycle only when the output register is still full
// synchronous reset clears coefficients, delay stores and control; cfg_ready is always high
// top level of the cascade fir filter unit; depends on cffu_pkg, cffu_ctrl,
// cffu_datapath and cascade_fir_filter_unit_assert.svh
`include "cascade_fir_filter_unit_assert.svh"

module cascade_fir_filter_unit #(
  parameter int STAGES          = cffu_pkg::DEF_STAGES,
  parameter int SCALE_SHIFT     = cffu_pkg::DEF_SCALE_SHIFT,
  parameter int COEFF_FRAC_BITS = cffu_pkg::DEF_COEFF_FRAC_BITS,
  parameter int SAMPLE_WIDTH    = cffu_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]   sample_out,
  output logic                             clipped,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cffu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cffu_pkg::REG_W-1:0]       cfg_data
);

  cffu_pkg::cmd_t    cmd;
  cffu_pkg::status_t status;

  assign cfg_ready = 1'b1;

  cffu_ctrl #(
    .STAGES (STAGES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cffu_datapath #(
    .STAGES          (STAGES),
    .SCALE_SHIFT     (SCALE_SHIFT),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
    .SAMPLE_WIDTH    (SAMPLE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .cmd        (cmd),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .clipped    (clipped),
    .out_valid  (out_valid),
    .status     (status)
  );

  `CFFU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "sample accepted twice")
  `CFFU_ASSERT_NOW(a_finish_room, cmd.finish, !out_valid || out_ready, "waiting word overwritten")
  `CFFU_ASSERT_NOW(a_issue_busy, cmd.issue, !in_ready && !cmd.finish, "multiply outside run")

endmodule

>>> hdl/cffu_ctrl.sv
// sequencer for the cascade fir filter unit: one multiply issued per step, but for the last step of a run
// depends on cffu_pkg
module cffu_ctrl #(
  parameter int STAGES = cffu_pkg::DEF_STAGES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_ready,
  input  cffu_pkg::status_t status,
  output cffu_pkg::cmd_t    cmd
);

  localparam logic [cffu_pkg::STEP_W-1:0] LAST = cffu_pkg::STEP_W'(2 * STAGES);

  cffu_pkg::state_t state, state_next;
  logic [cffu_pkg::STEP_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cffu_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.sect     = cnt[cffu_pkg::SECT_FIELD_W:1];
    cmd.tap      = cnt[0];
    cmd.use_tap  = ~cnt[0];
    case (state)
      cffu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cnt_next = '0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = cffu_pkg::ST_RUN;
        end
      end
      cffu_pkg::ST_RUN: begin
        cmd.issue    = (cnt != LAST);
        cmd.use_prod = (cnt != '0);
        cnt_next     = cnt + cffu_pkg::STEP_W'(1);
        if (cnt == LAST) begin
          state_next = cffu_pkg::ST_FINISH;
        end
      end
      cffu_pkg::ST_FINISH: begin
        if (!status.out_full || out_ready) begin
          cmd.finish = 1'b1;
          state_next = cffu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cffu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/cffu_datapath.sv
// datapath: coefficient registers, delay stores, shared multiplier,
// saturating accumulator and output register; depends on cffu_pkg
module cffu_datapath #(
  parameter int STAGES          = cffu_pkg::DEF_STAGES,
  parameter int SCALE_SHIFT     = cffu_pkg::DEF_SCALE_SHIFT,
  parameter int COEFF_FRAC_BITS = cffu_pkg::DEF_COEFF_FRAC_BITS,
  parameter int SAMPLE_WIDTH    = cffu_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [cffu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cffu_pkg::REG_W-1:0]        cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
  input  cffu_pkg::cmd_t                    cmd,
  input  logic                              out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]    sample_out,
  output logic                              clipped,
  output logic                              out_valid,
  output cffu_pkg::status_t                 status
);

  localparam int SECT_W = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int ACC_W  = cffu_pkg::ACC_W;
  localparam int PROD_W = cffu_pkg::PROD_W;
  localparam int SUM_W  = cffu_pkg::SUM_W;
  localparam int COEFF_W = cffu_pkg::COEFF_W;

  localparam logic signed [ACC_W-1:0] SMAX =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;

  logic [cffu_pkg::REG_W-1:0] coeff_regs [cffu_pkg::NUM_REGS];
  logic signed [ACC_W-1:0]    newest [STAGES];
  logic signed [ACC_W-1:0]    older  [STAGES];

  logic signed [PROD_W-1:0]   prod;
  logic signed [SUM_W-1:0]    acc;
  logic signed [ACC_W-1:0]    xin;
  logic                       clip;

  logic [SECT_W-1:0]          sidx;
  logic [cffu_pkg::REG_W-1:0] creg;
  logic signed [COEFF_W-1:0]  coeff;
  logic signed [ACC_W-1:0]    mul_a;
  logic signed [PROD_W-1:0]   prod_sh;
  logic signed [SUM_W-1:0]    sum;
  logic signed [ACC_W-1:0]    sum_sat;
  logic                       sum_clip;
  logic signed [ACC_W-1:0]    scaled;
  logic signed [ACC_W-1:0]    out_sat;
  logic                       out_clip;

  assign sidx  = cmd.sect[SECT_W-1:0];
  assign creg  = coeff_regs[{cmd.tap, cmd.sect[cffu_pkg::SECT_FIELD_W-1:2]}];
  assign coeff = creg[cmd.sect[1:0]*COEFF_W +: COEFF_W];
  assign mul_a = cmd.tap ? older[sidx] : newest[sidx];

  assign prod_sh = prod >>> COEFF_FRAC_BITS;
  assign sum     = acc + SUM_W'(prod_sh);

  always_comb begin
    sum_clip = 1'b0;
    sum_sat  = sum[ACC_W-1:0];
    if (sum > cffu_pkg::ACC_MAX) begin
      sum_clip = 1'b1;
      sum_sat  = cffu_pkg::ACC_MAX[ACC_W-1:0];
    end else if (sum < cffu_pkg::ACC_MIN) begin
      sum_clip = 1'b1;
      sum_sat  = cffu_pkg::ACC_MIN[ACC_W-1:0];
    end
  end

  assign scaled = xin >>> SCALE_SHIFT;

  always_comb begin
    out_clip = 1'b0;
    out_sat  = scaled;
    if (scaled > SMAX) begin
      out_clip = 1'b1;
      out_sat  = SMAX;
    end else if (scaled < SMIN) begin
      out_clip = 1'b1;
      out_sat  = SMIN;
    end
  end

  // coefficient registers and delay stores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cffu_pkg::NUM_REGS; i++) begin
        coeff_regs[i] <= '0;
      end
      for (int i = 0; i < STAGES; i++) begin
        newest[i] <= '0;
        older[i]  <= '0;
      end
    end else begin
      if (cfg_valid && (cfg_index < cffu_pkg::CFG_INDEX_W'(cffu_pkg::NUM_REGS))) begin
        coeff_regs[cfg_index[cffu_pkg::REG_SEL_W-1:0]] <= cfg_data;
      end
      if (cmd.issue && cmd.tap) begin
        older[sidx]  <= newest[sidx];
        newest[sidx] <= xin;
      end
    end
  end

  // multiply, accumulate and output register
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      prod <= mul_a * coeff;
    end
    if (cmd.load) begin
      xin  <= ACC_W'(sample_in);
      clip <= 1'b0;
    end else if (cmd.use_prod) begin
      if (cmd.use_tap) begin
        xin  <= sum_sat;
        clip <= clip | sum_clip;
      end else begin
        acc <= SUM_W'(xin) + SUM_W'(prod_sh);
      end
    end
    if (cmd.finish) begin
      sample_out <= out_sat[SAMPLE_WIDTH-1:0];
      clipped    <= clip | out_clip;
    end
  end

  // output word flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_full = out_valid;

endmodule

>>> sim/tb.sv
// self-checking testbench for cascade_fir_filter_unit, sixteen-section cascade fir filter
// depends on cffu_pkg and the filter rtl; directed table first, then randomised phases
// each word is checked against a known table value or the in-bench saturating chain model
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cffu_pkg::*;

  localparam int SW = DEF_SAMPLE_WIDTH;
  localparam int LATENCY = 2 * DEF_STAGES + 3;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES = 10;
  localparam int PHASE_SAMPLES = 140;
  localparam longint SMP_HI = (longint'(1) << (SW - 1)) - 1;
  localparam longint SMP_LO = -SMP_HI - 1;
  localparam longint ACC_HI = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef logic signed [SW-1:0] sample_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FIRST_A     = 4'd0,
    REG_FIRST_B     = 4'd1,
    REG_FIRST_C     = 4'd2,
    REG_FIRST_D     = 4'd3,
    REG_SECOND_A    = 4'd4,
    REG_SECOND_B    = 4'd5,
    REG_SECOND_C    = 4'd6,
    REG_SECOND_D    = 4'd7,
    REG_UNMAPPED_LO = 4'd8,
    REG_UNMAPPED_HI = 4'd15
  } reg_index_e;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_WRITE, ROW_GROUP} row_kind_e;

  typedef enum logic [2:0] {
    SET_ZERO, SET_GENTLE, SET_SPARSE, SET_WILD, SET_TOP, SET_BOTTOM
  } setting_e;

  typedef enum logic [1:0] {
    PACE_STEADY, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH
  } pace_e;

  typedef struct packed {
    sample_t smp;
    logic    clip;
  } filt_word_t;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [REG_W-1:0]       data;
    sample_t                smp;
    logic                   known;
    sample_t                want;
    logic                   want_clip;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sample_t sample_out;
  logic clipped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  logic [REG_W-1:0] coeff_bank [NUM_REGS] = '{default: '0};
  int newest_tap [DEF_STAGES];
  int older_tap [DEF_STAGES];
  filt_word_t expected_words [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int words_checked = 0;
  int clipped_seen = 0;
  int samples_sent = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;

  setting_e plan [PHASES] = '{
    SET_GENTLE, SET_SPARSE, SET_WILD, SET_ZERO, SET_GENTLE,
    SET_TOP, SET_SPARSE, SET_BOTTOM, SET_GENTLE, SET_SPARSE
  };

  stim_row_t dir_rows [34] = '{
    '{ROW_SAMPLE, REG_FIRST_A, '0, 16'sd0, 1'b1, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, 16'sd32767, 1'b1, 16'sd1023, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, -16'sd32768, 1'b1, -16'sd1024, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, -16'sd1, 1'b1, -16'sd1, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, 16'sd1, 1'b1, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, -16'sd33, 1'b1, -16'sd2, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, 16'sd32, 1'b1, 16'sd1, 1'b0},
    '{ROW_WRITE, REG_UNMAPPED_LO, 64'hffff_ffff_ffff_ffff, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_UNMAPPED_HI, 64'ha5a5_5a5a_a5a5_5a5a, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, 16'sd100, 1'b1, 16'sd3, 1'b0},
    '{ROW_GROUP, REG_FIRST_A, 64'h7fff_7fff_7fff_7fff, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_GROUP, REG_SECOND_A, 64'h7fff_7fff_7fff_7fff, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, 16'sd32767, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, 16'sd32767, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, -16'sd32768, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, -16'sd32768, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_GROUP, REG_FIRST_A, 64'h8000_8000_8000_8000, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_GROUP, REG_SECOND_A, 64'h8000_8000_8000_8000, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, -16'sd32768, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, 16'sd32767, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, -16'sd32768, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, 16'sd1, 1'b0, 16'sd0, 1'b0},
    '{ROW_GROUP, REG_FIRST_A, 64'h4000_4000_4000_4000, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_GROUP, REG_SECOND_A, 64'h0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, 16'sd1000, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, 16'sd1000, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, -16'sd1000, 1'b0, 16'sd0, 1'b0},
    '{ROW_GROUP, REG_FIRST_A, 64'h0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_FIRST_A, 64'h0000_0000_c000_2000, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, -16'sd7, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, 16'sd5, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, -16'sd3, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, REG_FIRST_A, '0, 16'sd0, 1'b0, 16'sd0, 1'b0}
  };

  cascade_fir_filter_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .clipped    (clipped),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // advances the sixteen delay pairs and returns the scaled, saturated word
  function automatic filt_word_t filter_sample(input sample_t x);
    filt_word_t res;
    longint v, c1, c2, sum;
    v = x;
    res.clip = 1'b0;
    for (int k = 0; k < DEF_STAGES; k++) begin
      c1 = $signed(coeff_bank[REG_FIRST_A + k / 4][16 * (k % 4) +: COEFF_W]);
      c2 = $signed(coeff_bank[REG_SECOND_A + k / 4][16 * (k % 4) +: COEFF_W]);
      sum = v + ((longint'(newest_tap[k]) * c1) >>> DEF_COEFF_FRAC_BITS)
              + ((longint'(older_tap[k]) * c2) >>> DEF_COEFF_FRAC_BITS);
      if (sum > ACC_HI) begin
        sum = ACC_HI;
        res.clip = 1'b1;
      end else if (sum < ACC_LO) begin
        sum = ACC_LO;
        res.clip = 1'b1;
      end
      older_tap[k] = newest_tap[k];
      newest_tap[k] = int'(v);
      v = sum;
    end
    v = v >>> DEF_SCALE_SHIFT;
    if (v > SMP_HI) begin
      v = SMP_HI;
      res.clip = 1'b1;
    end else if (v < SMP_LO) begin
      v = SMP_LO;
      res.clip = 1'b1;
    end
    res.smp = v[SW-1:0];
    return res;
  endfunction

  function automatic logic [COEFF_W-1:0] pick_coeff(input setting_e kind);
    case (kind)
      SET_GENTLE: return COEFF_W'($urandom_range(4096) - 2048);
      SET_SPARSE: return ($urandom_range(3) == 0) ? COEFF_W'($urandom_range(32768) - 16384) : '0;
      SET_WILD:   return COEFF_W'($urandom);
      SET_TOP:    return 16'h7fff;
      SET_BOTTOM: return 16'h8000;
      default:    return '0;
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0:       return sample_t'(SMP_HI);
          1:       return sample_t'(SMP_LO);
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2: return sample_t'($urandom_range(512) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic push_sample(input sample_t s, input logic known, input sample_t want,
                             input logic want_clip);
    filt_word_t w;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (!in_ready);
    w = filter_sample(s);
    if (known) begin
      w.smp = want;
      w.clip = want_clip;
    end
    expected_words.push_back(w);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_REGS)
      coeff_bank[idx] = data;
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  task automatic load_setting(input setting_e kind);
    logic [REG_W-1:0] word;
    for (int r = REG_FIRST_A; r <= REG_SECOND_D; r++) begin
      for (int j = 0; j < 4; j++)
        word[16 * j +: COEFF_W] = pick_coeff(kind);
      write_reg(CFG_INDEX_W'(r), word);
    end
    if ($urandom_range(1) == 1)
      write_reg(CFG_INDEX_W'($urandom_range(REG_UNMAPPED_HI, REG_UNMAPPED_LO)),
                {$urandom, $urandom});
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : word_check
    filt_word_t head;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, got sample_out %0d clipped %0b",
                 $time, sample_out, clipped);
        mismatches++;
      end else begin
        head = expected_words.pop_front();
        words_checked++;
        if (clipped)
          clipped_seen++;
        if (sample_out !== head.smp) begin
          $display("%0t: sample_out expected %0d got %0d", $time, $signed(head.smp), sample_out);
          mismatches++;
        end
        if (clipped !== head.clip) begin
          $display("%0t: clipped expected %0b got %0b", $time, head.clip, clipped);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d words outstanding",
               $time, QUIET_LIMIT, expected_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_SAMPLE: push_sample(dir_rows[i].smp, dir_rows[i].known, dir_rows[i].want,
                                dir_rows[i].want_clip);
        ROW_WRITE: begin
          settle();
          write_reg(dir_rows[i].index, dir_rows[i].data);
        end
        default: begin
          settle();
          for (int g = 0; g < 4; g++)
            write_reg(CFG_INDEX_W'(dir_rows[i].index + g), dir_rows[i].data);
        end
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      load_setting(plan[p]);
      case (pace_e'(p % 4))
        PACE_STEADY: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        PACE_SENDER_GAPS: begin
          send_idle_pct = 52;
          recv_stall_pct = 0;
        end
        PACE_RECEIVER_STALLS: begin
          send_idle_pct = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct = 13;
          recv_stall_pct = 13;
        end
      endcase
      for (int n = 0; n < PHASE_SAMPLES; n++)
        push_sample(pick_sample(), 1'b0, '0, 1'b0);
    end

    settle();
    repeat (2 * LATENCY) @(posedge clk);
    $display("run covered %0d samples and %0d register writes over %0d coefficient settings",
             samples_sent, reg_writes, PHASES + 5);
    $display("%0d filtered words compared, %0d flagged as clipped", words_checked, clipped_seen);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/cffu_pkg.sv
hdl/cffu_ctrl.sv
hdl/cffu_datapath.sv
hdl/cascade_fir_filter_unit.sv
sim/tb.sv
